// ===== rtl/i2cbr_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbr_pkg: shared types and constants for the I2C bus recovery sequencer
// Configuration record, result word type, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbr_pkg;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_LIMIT    = 3'd4;

    // Reset values of the registers
    localparam logic [31:0] RST_SETTLE_TICKS  = 32'd2500;
    localparam logic [15:0] RST_HALF_PERIOD   = 16'd10;
    localparam logic [31:0] RST_POLL_INTERVAL = 32'd100;
    localparam logic [4:0]  RST_POLL_LIMIT    = 5'd20;
    localparam logic [4:0]  RST_PULSE_LIMIT   = 5'd20;

    // Input word op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Result codes
    localparam logic [1:0] CODE_OK          = 2'd0;
    localparam logic [1:0] CODE_SCL_STUCK   = 2'd1;
    localparam logic [1:0] CODE_STRETCH_TMO = 2'd2;
    localparam logic [1:0] CODE_SDA_STUCK   = 2'd3;

    typedef struct packed {
        logic [31:0] settle_ticks;
        logic [15:0] half_period_ticks;
        logic [31:0] poll_interval_ticks;
        logic [4:0]  poll_limit;
        logic [4:0]  pulse_limit;
    } t_cfg;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       pullups_on;
        logic       busy_res;
        logic       done_res;
        logic [1:0] result_code;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/i2cbr_in_if.sv =====
// ----------------------------------------------------------------------------
// i2cbr_in_if: input channel of the recovery sequencer
// One word per tick or start command, with the sampled line levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cbr_in_if;
    logic valid;
    logic ready;
    logic op;
    logic scl_level;
    logic sda_level;

    modport source (output valid, output op, output scl_level, output sda_level,
                    input ready);
    modport sink   (input valid, input op, input scl_level, input sda_level,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cbr_out_if.sv =====
// ----------------------------------------------------------------------------
// i2cbr_out_if: result channel of the recovery sequencer
// One word per accepted input word: line drives, status and result code.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cbr_out_if;
    logic       valid;
    logic       ready;
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       pullups_on;
    logic       busy_res;
    logic       done_res;
    logic [1:0] result_code;

    modport source (output valid, output scl_drive_low, output sda_drive_low,
                    output pullups_on, output busy_res, output done_res,
                    output result_code, input ready);
    modport sink   (input valid, input scl_drive_low, input sda_drive_low,
                    input pullups_on, input busy_res, input done_res,
                    input result_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cbr_cfg.sv =====
// ----------------------------------------------------------------------------
// i2cbr_cfg: configuration register file
// Five write-only registers, loaded from a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbr_cfg
    import i2cbr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output t_cfg                        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks        <= RST_SETTLE_TICKS;
            r_cfg.half_period_ticks   <= RST_HALF_PERIOD;
            r_cfg.poll_interval_ticks <= RST_POLL_INTERVAL;
            r_cfg.poll_limit          <= RST_POLL_LIMIT;
            r_cfg.pulse_limit         <= RST_PULSE_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SETTLE_TICKS:  r_cfg.settle_ticks        <= i_cfg_wdata;
                REG_HALF_PERIOD:   r_cfg.half_period_ticks   <= i_cfg_wdata[15:0];
                REG_POLL_INTERVAL: r_cfg.poll_interval_ticks <= i_cfg_wdata;
                REG_POLL_LIMIT:    r_cfg.poll_limit          <= i_cfg_wdata[4:0];
                REG_PULSE_LIMIT:   r_cfg.pulse_limit         <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/i2cbr_core.sv =====
// ----------------------------------------------------------------------------
// i2cbr_core: recovery state machine with result register
// Updates the sequence state once per accepted word and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbr_core
    import i2cbr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_op,
    input  wire logic i_scl_level,
    input  wire logic i_sda_level,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_PULSE_LOW,
        PH_PULSE_HIGH,
        PH_POLL,
        PH_STOP_LOW,
        PH_STOP_REL
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [31:0] r_tick,   n_tick;
    logic [4:0]  r_pulses, n_pulses;
    logic [4:0]  r_polls,  n_polls;
    logic [1:0]  r_code,   n_code;
    logic        r_res_valid;
    t_res        r_res,    n_res;
    logic        w_accept;

    // The result register frees itself as it is read
    assign o_in_ready = !r_res_valid || i_res_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        logic        wait_done;
        logic        chk_sda;
        logic        done;
        logic [31:0] half_ext;
        logic        busy;

        n_phase   = r_phase;
        n_tick    = r_tick;
        n_pulses  = r_pulses;
        n_polls   = r_polls;
        n_code    = r_code;
        chk_sda   = 1'b0;
        done      = 1'b0;
        half_ext  = {16'd0, i_cfg.half_period_ticks};
        wait_done = (r_tick <= 32'd1);

        if (i_op == OP_START) begin
            n_phase  = PH_SETTLE;
            n_tick   = i_cfg.settle_ticks;
            n_pulses = '0;
            n_polls  = '0;
        end else begin
            if (r_phase != PH_IDLE) begin
                n_tick = wait_done ? 32'd0 : r_tick - 32'd1;
            end
            unique case (r_phase)
                PH_SETTLE: begin
                    if (wait_done) begin
                        if (!i_scl_level) begin
                            n_phase = PH_IDLE;
                            n_code  = CODE_SCL_STUCK;
                            done    = 1'b1;
                        end else begin
                            n_pulses = i_cfg.pulse_limit;
                            chk_sda  = 1'b1;
                        end
                    end
                end
                PH_PULSE_LOW: begin
                    if (wait_done) begin
                        n_phase = PH_PULSE_HIGH;
                        n_tick  = half_ext;
                    end
                end
                PH_PULSE_HIGH: begin
                    if (wait_done) begin
                        if (!i_scl_level) begin
                            n_polls = i_cfg.poll_limit;
                            if (i_cfg.poll_limit == 5'd0) begin
                                n_phase = PH_IDLE;
                                n_code  = CODE_STRETCH_TMO;
                                done    = 1'b1;
                            end else begin
                                n_phase = PH_POLL;
                                n_tick  = i_cfg.poll_interval_ticks;
                            end
                        end else begin
                            chk_sda = 1'b1;
                        end
                    end
                end
                PH_POLL: begin
                    if (wait_done) begin
                        n_polls = r_polls - 5'd1;
                        if (i_scl_level) begin
                            chk_sda = 1'b1;
                        end else if (n_polls == 5'd0) begin
                            n_phase = PH_IDLE;
                            n_code  = CODE_STRETCH_TMO;
                            done    = 1'b1;
                        end else begin
                            n_tick = i_cfg.poll_interval_ticks;
                        end
                    end
                end
                PH_STOP_LOW: begin
                    if (wait_done) begin
                        n_phase = PH_STOP_REL;
                        n_tick  = half_ext;
                    end
                end
                PH_STOP_REL: begin
                    if (wait_done) begin
                        n_phase = PH_IDLE;
                        n_code  = CODE_OK;
                        done    = 1'b1;
                    end
                end
                default: begin
                    // idle, or an unused code: drop to idle
                    n_phase = PH_IDLE;
                end
            endcase

            // SDA decision: clock again, give up, or form the STOP
            if (chk_sda) begin
                if (!i_sda_level) begin
                    if (n_pulses != 5'd0) begin
                        n_pulses = n_pulses - 5'd1;
                        n_phase  = PH_PULSE_LOW;
                        n_tick   = half_ext;
                    end else begin
                        n_phase = PH_IDLE;
                        n_code  = CODE_SDA_STUCK;
                        done    = 1'b1;
                    end
                end else begin
                    n_phase = PH_STOP_LOW;
                    n_tick  = half_ext;
                end
            end
        end

        busy                = (n_phase != PH_IDLE);
        n_res.scl_drive_low = (n_phase == PH_PULSE_LOW);
        n_res.sda_drive_low = (n_phase == PH_STOP_LOW);
        n_res.pullups_on    = busy || (n_code != CODE_OK);
        n_res.busy_res      = busy;
        n_res.done_res      = done;
        n_res.result_code   = n_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_pulses    <= '0;
            r_polls     <= '0;
            r_code      <= CODE_OK;
            r_res_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase  <= n_phase;
                r_tick   <= n_tick;
                r_pulses <= n_pulses;
                r_polls  <= n_polls;
                r_code   <= n_code;
                r_res    <= n_res;
            end
            if (w_accept) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/i2c_bus_recovery_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_bus_recovery_sequencer: I2C bus clear sequencer
// Frees a hung bus by clocking SCL until SDA releases, then issues a STOP.
//
//   channel   dir  word contents                                   handshake
//   i_in_ch   in   op, scl_level, sda_level                        valid/ready
//   o_out_ch  out  scl/sda drive, pullups, busy, done, code        valid/ready
//   i_cfg_*   in   register index, 32-bit write data               write enable
//
// One word per cycle while results are read: each accepted word updates the
// sequence state and its result appears in the result register the next cycle.
// A stalled result register still takes a new word when it is read in the
// same cycle; otherwise the input waits.
// Reset clears the state to idle, result code 0 and register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bus_recovery_sequencer
    import i2cbr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    i2cbr_in_if.sink                    i_in_ch,
    i2cbr_out_if.source                 o_out_ch,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg w_cfg;
    t_res w_res;
    logic w_in_ready;
    logic w_res_valid;

    i2cbr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    i2cbr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (w_in_ready),
        .i_op        (i_in_ch.op),
        .i_scl_level (i_in_ch.scl_level),
        .i_sda_level (i_in_ch.sda_level),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_out_ch.ready),
        .o_res       (w_res)
    );

    assign i_in_ch.ready          = w_in_ready;
    assign o_out_ch.valid         = w_res_valid;
    assign o_out_ch.scl_drive_low = w_res.scl_drive_low;
    assign o_out_ch.sda_drive_low = w_res.sda_drive_low;
    assign o_out_ch.pullups_on    = w_res.pullups_on;
    assign o_out_ch.busy_res      = w_res.busy_res;
    assign o_out_ch.done_res      = w_res.done_res;
    assign o_out_ch.result_code   = w_res.result_code;

endmodule

`default_nettype wire

// ===== rtl/i2cbr_checker.sv =====
// ----------------------------------------------------------------------------
// i2cbr_checker: port-level checks for the recovery sequencer
// Watches the channel ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbr_checker
    import i2cbr_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_scl_drive_low,
    input wire logic       i_sda_drive_low,
    input wire logic       i_pullups_on,
    input wire logic       i_busy_res,
    input wire logic       i_done_res,
    input wire logic [1:0] i_result_code
);

    // A finishing word never shows the sequence still running
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res |-> !i_busy_res)
        else $error("done word shows busy");

    // SCL and SDA are never pulled low together, and only while running
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_scl_drive_low || i_sda_drive_low)
        |-> i_busy_res && !(i_scl_drive_low && i_sda_drive_low))
        else $error("line driven low outside a running sequence");

    // Pull-ups stay on while running or after an error finish, and drop after a clean finish
    a_pullups: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_busy_res || (i_done_res && i_result_code != CODE_OK))
        |-> i_pullups_on)
        else $error("pull-ups off while running or after an error");

    a_ok_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res && i_result_code == CODE_OK |-> !i_pullups_on)
        else $error("pull-ups left on after a clean finish");

    // Every accepted word yields a result word on the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted word produced no result");

endmodule

bind i2c_bus_recovery_sequencer i2cbr_checker u_i2cbr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_ch.valid),
    .i_in_ready      (i_in_ch.ready),
    .i_out_valid     (o_out_ch.valid),
    .i_scl_drive_low (o_out_ch.scl_drive_low),
    .i_sda_drive_low (o_out_ch.sda_drive_low),
    .i_pullups_on    (o_out_ch.pullups_on),
    .i_busy_res      (o_out_ch.busy_res),
    .i_done_res      (o_out_ch.done_res),
    .i_result_code   (o_out_ch.result_code)
);

`default_nettype wire
